FILE: rtl/frld_pkg.sv
// ----------------------------------------------------------------------------
// Flagged run-length decoder package
// Shared types and constants for the decoder, its control and its emitter.
// ----------------------------------------------------------------------------
`default_nettype none

package frld_pkg;

	localparam int unsigned ADDR_W  = 14;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned COUNT_W = 6;

	localparam logic [BYTE_W-1:0] BYTE_ZERO = 8'h00;
	localparam logic [BYTE_W-1:0] BYTE_ONES = 8'hff;

	typedef enum logic [1:0] {
		MODE_CTRL = 2'd0,
		MODE_RUN  = 2'd1,
		MODE_LIT  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		FLAG_ZERO   = 2'd0,
		FLAG_ONES   = 2'd1,
		FLAG_REPEAT = 2'd2,
		FLAG_LITERAL = 2'd3
	} flag_t;

	typedef struct packed {
		logic [BYTE_W-1:0] in_byte;
		logic              last_byte;
	} in_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic [ADDR_W-1:0] write_address;
		logic              last_of_run;
	} out_item_t;

	typedef struct packed {
		logic               load;
		logic               go;
		logic [BYTE_W-1:0]  value;
		logic [COUNT_W-1:0] count;
		logic [ADDR_W-1:0]  base;
	} job_t;

endpackage

`default_nettype wire

FILE: rtl/frld_ctrl.sv
// ----------------------------------------------------------------------------
// Flagged run-length decoder token control
// Parses control bytes, tracks the token in progress and issues run jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module frld_ctrl import frld_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire in_item_t          item,
	input  wire logic [ADDR_W-1:0] start_address,
	input  wire logic [ADDR_W-1:0] cur_address,
	output job_t                   job
);

	mode_t              mode_q, mode_d;
	logic [COUNT_W-1:0] pend_q, pend_d;
	logic               block_start_q;
	flag_t              flag;
	logic [COUNT_W-1:0] n;

	assign flag = flag_t'(item.in_byte[7:6]);
	assign n    = item.in_byte[COUNT_W-1:0];

	always_comb begin
		mode_d = mode_q;
		pend_d = pend_q;
		if (accept) begin
			unique case (mode_q)
				MODE_RUN: begin
					mode_d = MODE_CTRL;
					pend_d = '0;
				end
				MODE_LIT: begin
					if (pend_q == '0) begin
						mode_d = MODE_CTRL;
					end else begin
						pend_d = pend_q - 1'b1;
					end
				end
				default: begin
					mode_d = MODE_CTRL;
					unique case (flag)
						FLAG_REPEAT: begin
							mode_d = MODE_RUN;
							pend_d = n;
						end
						FLAG_LITERAL: begin
							mode_d = MODE_LIT;
							pend_d = n;
						end
						default: ;
					endcase
				end
			endcase
			if (item.last_byte) begin
				mode_d = MODE_CTRL;
				pend_d = '0;
			end
		end
	end

	always_comb begin
		job.load  = accept;
		job.go    = 1'b0;
		job.value = item.in_byte;
		job.count = '0;
		job.base  = block_start_q ? start_address : cur_address;
		unique case (mode_q)
			MODE_RUN: begin
				job.go    = accept;
				job.count = pend_q;
			end
			MODE_LIT: begin
				job.go = accept;
			end
			default: begin
				unique case (flag)
					FLAG_ZERO: begin
						job.go    = accept;
						job.value = BYTE_ZERO;
						job.count = n;
					end
					FLAG_ONES: begin
						job.go    = accept;
						job.value = BYTE_ONES;
						job.count = n;
					end
					default: ;
				endcase
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_CTRL;
			pend_q        <= '0;
			block_start_q <= 1'b1;
		end else begin
			mode_q <= mode_d;
			pend_q <= pend_d;
			if (accept) begin
				block_start_q <= item.last_byte;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/frld_emit.sv
// ----------------------------------------------------------------------------
// Flagged run-length decoder emitter
// Repeats one byte over a down-counter, stepping the write address each time.
// ----------------------------------------------------------------------------
`default_nettype none

module frld_emit import frld_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire job_t              job,
	output logic                   busy,
	output logic [ADDR_W-1:0]      cur_address,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output out_item_t              out_data
);

	logic               busy_q;
	logic [COUNT_W-1:0] rem_q;
	logic [BYTE_W-1:0]  val_q;
	logic [ADDR_W-1:0]  addr_q;
	logic               out_valid_q;
	out_item_t          out_q;
	logic               fire;

	assign fire        = busy_q && (!out_valid_q || !out_stall);
	assign busy        = busy_q;
	assign cur_address = addr_q;
	assign out_valid   = out_valid_q;
	assign out_data    = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			rem_q       <= '0;
			addr_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (job.load) begin
				addr_q <= job.base;
			end
			if (job.go) begin
				busy_q <= 1'b1;
				rem_q  <= job.count;
			end else if (fire) begin
				addr_q <= addr_q + 1'b1;
				if (rem_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					rem_q <= rem_q - 1'b1;
				end
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job.go) begin
			val_q <= job.value;
		end
		if (fire) begin
			out_q.out_byte      <= val_q;
			out_q.write_address <= addr_q;
			out_q.last_of_run   <= (rem_q == '0);
		end
	end

endmodule

`default_nettype wire

FILE: rtl/flagged_rle_decoder_top.sv
// A result passes through the emitter's run registers and then its output register.
// Throughput: one decoded byte per cycle while the output is not stalled, from a
// single shared down-counter and address incrementer; the input is stalled while
// the emitter is busy, so no byte is taken until the current run is emitted.
// Reset: asynchronous, active low; clears the token state, the address and the
// start register, and the next byte opens a new block.
// ----------------------------------------------------------------------------
// Flagged run-length decoder
// Turns a flagged run-length byte stream into addressed video memory writes.
// ----------------------------------------------------------------------------
`default_nettype none

module flagged_rle_decoder_top import frld_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire in_item_t          in_data,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output out_item_t              out_data,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [ADDR_W-1:0] cfg_data
);

	logic [ADDR_W-1:0] start_q;
	logic [ADDR_W-1:0] cur_address;
	logic              busy;
	logic              accept;
	job_t              job;

	assign cfg_ready = 1'b1;
	assign in_stall  = busy;
	assign accept    = in_valid && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			start_q <= cfg_data;
		end
	end

	frld_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.item          (in_data),
		.start_address (start_q),
		.cur_address   (cur_address),
		.job           (job)
	);

	frld_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.job         (job),
		.busy        (busy),
		.cur_address (cur_address),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

endmodule

`default_nettype wire

FILE: rtl/frld_checker.sv
// ----------------------------------------------------------------------------
// Flagged run-length decoder checker
// Port-level assertions on output ordering, input stalling and addressing within a run.
// ----------------------------------------------------------------------------
`default_nettype none

module frld_checker import frld_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_stall,
	input wire logic      out_valid,
	input wire logic      out_stall,
	input wire out_item_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled output transaction changed");

	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last_of_run |-> in_stall)
		else $error("input taken while a run is still being emitted");

	a_run_next: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_data.last_of_run |=> out_valid)
		else $error("run stopped before its final transaction");

	a_run_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_data.last_of_run |=>
		out_data.write_address == $past(out_data.write_address) + 1'b1)
		else $error("write address did not step within a run");

endmodule

bind flagged_rle_decoder_top frld_checker u_frld_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

`default_nettype wire
